// ----- rtl/core/ilist_pkg.sv -----
// Shared types and codes of the indexed list engine.
// Holds the request and result items, request and status codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package ilist_pkg;

	// Request codes carried in req_type.
	localparam logic [2:0] REQ_APPEND    = 3'd0;
	localparam logic [2:0] REQ_INSERT    = 3'd1;
	localparam logic [2:0] REQ_OVERWRITE = 3'd2;
	localparam logic [2:0] REQ_READ      = 3'd3;
	localparam logic [2:0] REQ_REMOVE    = 3'd4;

	// Status codes returned with every result.
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	// Widths of the item fields.
	localparam int unsigned FIELD_DW = 32;
	localparam int unsigned FIELD_PW = 8;
	localparam int unsigned FIELD_CW = 9;

	// One request item.
	typedef struct packed {
		logic [2:0]          req_type;
		logic [FIELD_PW-1:0] position;
		logic [FIELD_DW-1:0] data_value;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [FIELD_DW-1:0] read_value;
		logic [1:0]          status;
		logic [FIELD_CW-1:0] entry_count;
	} out_item_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_RDWAIT
	} state_t;

endpackage

// ----- rtl/core/indexed_list_insert_remove_engine_unit.sv -----
// Top level of the indexed list engine: request sequencer, live count and result register.
// Depends on ilist_pkg and ilist_ram.
//
//   channel  | ports                   | handshake
//   ---------+-------------------------+---------------------------------------
//   request  | start, busy, request    | item taken when start high, busy low
//   result   | done, result            | item valid for the one cycle done high
//
// Overwrite, rejected requests and unknown codes keep busy low; their result is registered and
// appears in the cycle after the request is taken. A read holds busy for one cycle. Append, insert
// and remove move n entries through the single store port pair, one a cycle, and hold busy until
// all moves are done. The result strobe follows the last busy cycle.
// Reset clears the count and the sequencer; stored entries are undefined until written.
// The receiver cannot stall the result.
`timescale 1ns / 1ps

module indexed_list_insert_remove_engine_unit
	import ilist_pkg::*;
#(
	parameter int unsigned CAPACITY   = 256,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);

	// Stored word width, count width, address width and compare width.
	localparam int unsigned SW = (DATA_WIDTH < FIELD_DW) ? DATA_WIDTH : FIELD_DW;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned XW = (CW > FIELD_PW) ? CW : FIELD_PW;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   rem_q, rem_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic [AW-1:0]   wptr_q, wptr_d;
	logic [AW-1:0]   ip_q, ip_d;
	logic [SW-1:0]   word_q, word_d;
	logic            ins_q, ins_d;
	logic            pend_q, pend_d;
	logic            done_q, done_d;
	out_item_t       res_q, res_d;

	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [SW-1:0]   mem_wdata, mem_rdata;

	logic [XW-1:0]   pos_x, cnt_x, ip_x;
	logic            full, in_range;
	logic [AW-1:0]   ptr_inc, ptr_dec;

	// Entry store.
	ilist_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(SW)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	// Request checks against the live count.
	assign pos_x    = XW'(request.position);
	assign cnt_x    = XW'(count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign in_range = (pos_x < cnt_x);
	assign ip_x     = ((request.req_type == REQ_APPEND) || (pos_x > cnt_x)) ? cnt_x : pos_x;

	// Shared pointer step unit.
	assign ptr_inc = ptr_q + AW'(1);
	assign ptr_dec = ptr_q - AW'(1);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		wptr_q <= wptr_d;
		ip_q   <= ip_d;
		word_q <= word_d;
		ins_q  <= ins_d;
		res_q  <= res_d;
	end

	// Next state, store control and result.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rem_d     = rem_q;
		ptr_d     = ptr_q;
		wptr_d    = wptr_q;
		ip_d      = ip_q;
		word_d    = word_q;
		ins_d     = ins_q;
		pend_d    = 1'b0;
		done_d    = 1'b0;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = ip_q;
		mem_wdata = word_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					word_d = request.data_value[SW-1:0];
					res_d.read_value  = '0;
					res_d.status      = STAT_RANGE;
					res_d.entry_count = FIELD_CW'(count_q);
					unique case (request.req_type)
						REQ_APPEND, REQ_INSERT: begin
							if (full) begin
								res_d.status = STAT_FULL;
								done_d       = 1'b1;
							end else begin
								ip_d    = AW'(ip_x);
								rem_d   = CW'(cnt_x - ip_x);
								ptr_d   = AW'(cnt_x - XW'(1));
								ins_d   = 1'b1;
								state_d = ST_SHIFT;
							end
						end
						REQ_OVERWRITE: begin
							if (in_range) begin
								mem_we           = 1'b1;
								mem_waddr        = AW'(pos_x);
								mem_wdata        = request.data_value[SW-1:0];
								res_d.read_value = FIELD_DW'(request.data_value[SW-1:0]);
								res_d.status     = STAT_DONE;
							end
							done_d = 1'b1;
						end
						REQ_READ: begin
							if (in_range) begin
								mem_re    = 1'b1;
								mem_raddr = AW'(pos_x);
								state_d   = ST_RDWAIT;
							end else begin
								done_d = 1'b1;
							end
						end
						REQ_REMOVE: begin
							if (in_range) begin
								rem_d   = CW'(cnt_x - pos_x - XW'(1));
								ptr_d   = AW'(pos_x + XW'(1));
								ins_d   = 1'b0;
								state_d = ST_SHIFT;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end

			ST_SHIFT: begin
				// Write back the entry read in the previous cycle.
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = wptr_q;
					mem_wdata = mem_rdata;
				end
				// Read the next entry to move: downward for insert, upward for remove.
				if (rem_q != '0) begin
					mem_re = 1'b1;
					ptr_d  = ins_q ? ptr_dec : ptr_inc;
					wptr_d = ins_q ? ptr_inc : ptr_dec;
					rem_d  = rem_q - CW'(1);
					pend_d = 1'b1;
				end else if (!pend_q) begin
					// All moves done: place the new word or drop the removed one.
					if (ins_q) begin
						mem_we    = 1'b1;
						mem_waddr = ip_q;
						mem_wdata = word_q;
						count_d   = count_q + CW'(1);
					end else begin
						count_d = count_q - CW'(1);
					end
					res_d.read_value  = '0;
					res_d.status      = STAT_DONE;
					res_d.entry_count = FIELD_CW'(count_d);
					done_d            = 1'b1;
					state_d           = ST_IDLE;
				end
			end

			ST_RDWAIT: begin
				res_d.read_value  = FIELD_DW'(mem_rdata);
				res_d.status      = STAT_DONE;
				res_d.entry_count = FIELD_CW'(count_q);
				done_d            = 1'b1;
				state_d           = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// The live count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("live count above capacity");

	// A pending move only exists while shifting.
	a_pend_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_SHIFT))
		else $error("pending move outside shift");

	// A taken item either reports at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("taken item neither reported nor in progress");

	// A full status only appears with a full list.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STAT_FULL)) |-> (count_q == CW'(CAPACITY)))
		else $error("full status with room left");

	// The count moves by at most one per item and only when a result is issued.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> done)
		else $error("count changed without a result");

endmodule

// ----- rtl/core/ilist_ram.sv -----
// Entry store of the indexed list engine: one write port and one read port.
// The read data is registered. Depends on nothing.
`timescale 1ns / 1ps

module ilist_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
